@@ sv/sgr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types and constants of the sixel glyph rasterizer.
// ----------------------------------------------------------------------------
package sgr_pkg;

   localparam logic [7:0] SIXEL_LOW  = 8'd63;
   localparam logic [7:0] SIXEL_HIGH = 8'd126;
   localparam logic [7:0] CH_SLASH   = 8'd47;
   localparam logic [7:0] CH_SEMI    = 8'd59;
   localparam logic [5:0] BAND_ROWS  = 6'd6;
   localparam logic [5:0] BAND_CAP   = 6'd60;

   localparam logic [4:0] CELL_WIDTH_RESET  = 5'd8;
   localparam logic [5:0] CELL_HEIGHT_RESET = 6'd10;

   localparam logic CSR_CELL_WIDTH  = 1'b0;
   localparam logic CSR_CELL_HEIGHT = 1'b1;

   typedef struct packed {
      logic [6:0] glyph_number;
      logic [3:0] column;
      logic [4:0] row_base;
      logic [5:0] column_bits;
      logic [5:0] row_mask;
   } rsp_type;

endpackage
`default_nettype wire

@@ sv/sgr_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_decoder
// Decodes one payload byte against the glyph, band and column counters and
// gives the next counter values and the column write, if any.
// ----------------------------------------------------------------------------
module sgr_decoder #(
   parameter int MAX_CELL_WIDTH  = 16,
   parameter int MAX_CELL_HEIGHT = 32,
   parameter int GLYPH_LIMIT     = 128,
   parameter int GW              = $clog2(GLYPH_LIMIT + 1)
) (
   input  wire  logic [7:0]    char_code,
   input  wire  logic          start_font,
   input  wire  logic [4:0]    width_cfg,
   input  wire  logic [5:0]    height_cfg,
   input  wire  logic [4:0]    column_count,
   input  wire  logic [5:0]    band_base,
   input  wire  logic [GW-1:0] glyph_count,
   output logic       [4:0]    column_next,
   output logic       [5:0]    band_next,
   output logic       [GW-1:0] glyph_next,
   output logic                emit,
   output sgr_pkg::rsp_type    result
);

   localparam logic [6:0]    MaxW  = 7'(MAX_CELL_WIDTH);
   localparam logic [6:0]    MaxH  = 7'(MAX_CELL_HEIGHT);
   localparam logic [GW-1:0] Limit = GW'(GLYPH_LIMIT);

   logic [4:0]    eff_w;
   logic [5:0]    eff_h;
   logic [4:0]    col0;
   logic [5:0]    band0;
   logic [GW-1:0] glyph0;
   logic [6:0]    rows;
   logic [5:0]    mask;
   logic [5:0]    pixels;
   logic          is_sixel;

   always_comb begin
      eff_w  = ({2'b00, width_cfg} < MaxW) ? width_cfg : MaxW[4:0];
      eff_h  = ({1'b0, height_cfg} < MaxH) ? height_cfg : MaxH[5:0];
      col0   = start_font ? 5'd0 : column_count;
      band0  = start_font ? 6'd0 : band_base;
      glyph0 = start_font ? '0 : glyph_count;

      rows   = {1'b0, eff_h} - {1'b0, band0};
      if (rows >= {1'b0, sgr_pkg::BAND_ROWS}) begin
         mask = 6'h3F;
      end else begin
         mask = 6'((7'd1 << rows[2:0]) - 7'd1);
      end
      pixels   = 6'(char_code - sgr_pkg::SIXEL_LOW) & mask;
      is_sixel = (char_code >= sgr_pkg::SIXEL_LOW) && (char_code <= sgr_pkg::SIXEL_HIGH);

      column_next = col0;
      band_next   = band0;
      glyph_next  = glyph0;
      emit        = 1'b0;

      if (char_code == sgr_pkg::CH_SLASH) begin
         column_next = 5'd0;
         if ({1'b0, band0} + {1'b0, sgr_pkg::BAND_ROWS} <= {1'b0, sgr_pkg::BAND_CAP}) begin
            band_next = band0 + sgr_pkg::BAND_ROWS;
         end
      end else if (char_code == sgr_pkg::CH_SEMI) begin
         column_next = 5'd0;
         band_next   = 6'd0;
         if (glyph0 < Limit) begin
            glyph_next = glyph0 + GW'(1);
         end
      end else if (is_sixel && (col0 < eff_w)) begin
         column_next = col0 + 5'd1;
         emit        = (band0 < eff_h) && (glyph0 < Limit);
      end

      result.glyph_number = glyph0[6:0];
      result.column       = col0[3:0];
      result.row_base     = band0[4:0];
      result.column_bits  = pixels;
      result.row_mask     = mask;
   end

endmodule
`default_nettype wire

@@ sv/sixel_glyph_rasterizer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sixel_glyph_rasterizer
// Turns a soft-font sixel byte stream into column writes for a glyph store.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, and its column write, if any,
// in the result register, shown on rsp_valid; the counter update is combinational.
// Throughput: one byte per cycle unless a column write is waiting on rsp_ready.
// Reset: counters clear to glyph 0, column 0, band 0; cell width 8, height 10.
// ----------------------------------------------------------------------------
module sixel_glyph_rasterizer #(
   parameter int MAX_CELL_WIDTH  = 16,
   parameter int MAX_CELL_HEIGHT = 32,
   parameter int GLYPH_LIMIT     = 128
) (
   input  wire  logic       clock,
   input  wire  logic       reset,
   input  wire  logic       req_valid,
   output logic             req_ready,
   input  wire  logic [7:0] req_char_code,
   input  wire  logic       req_start_font,
   output logic             rsp_valid,
   input  wire  logic       rsp_ready,
   output logic [6:0]       rsp_glyph_number,
   output logic [3:0]       rsp_column,
   output logic [4:0]       rsp_row_base,
   output logic [5:0]       rsp_column_bits,
   output logic [5:0]       rsp_row_mask,
   input  wire  logic       csr_we,
   input  wire  logic       csr_index,
   input  wire  logic [5:0] csr_wdata
);

   localparam int GW = $clog2(GLYPH_LIMIT + 1);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_char_ff;
   logic             in_start_ff;
   logic             out_valid_ff, out_valid_in;
   sgr_pkg::rsp_type out_ff;
   logic [4:0]       width_ff, width_in;
   logic [5:0]       height_ff, height_in;
   logic [4:0]       column_ff, column_in;
   logic [5:0]       band_ff, band_in;
   logic [GW-1:0]    glyph_ff, glyph_in;
   logic             advance;
   logic             emit;
   sgr_pkg::rsp_type result;

   sgr_decoder #(
      .MAX_CELL_WIDTH (MAX_CELL_WIDTH),
      .MAX_CELL_HEIGHT(MAX_CELL_HEIGHT),
      .GLYPH_LIMIT    (GLYPH_LIMIT),
      .GW             (GW)
   ) u_decoder (
      .char_code   (in_char_ff),
      .start_font  (in_start_ff),
      .width_cfg   (width_ff),
      .height_cfg  (height_ff),
      .column_count(column_ff),
      .band_base   (band_ff),
      .glyph_count (glyph_ff),
      .column_next (column_in),
      .band_next   (band_in),
      .glyph_next  (glyph_in),
      .emit        (emit),
      .result      (result)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !advance);
      if (advance) begin
         out_valid_in = emit;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ready;
      end
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            sgr_pkg::CSR_CELL_WIDTH: begin
               width_in = csr_wdata[4:0];
            end
            sgr_pkg::CSR_CELL_HEIGHT: begin
               height_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         width_ff     <= sgr_pkg::CELL_WIDTH_RESET;
         height_ff    <= sgr_pkg::CELL_HEIGHT_RESET;
         column_ff    <= 5'd0;
         band_ff      <= 6'd0;
         glyph_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         if (advance) begin
            column_ff <= column_in;
            band_ff   <= band_in;
            glyph_ff  <= glyph_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff  <= req_char_code;
         in_start_ff <= req_start_font;
      end
      if (advance && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_glyph_number = out_ff.glyph_number;
   assign rsp_column       = out_ff.column;
   assign rsp_row_base     = out_ff.row_base;
   assign rsp_column_bits  = out_ff.column_bits;
   assign rsp_row_mask     = out_ff.row_mask;

endmodule
`default_nettype wire

@@ tb/sgr_raster_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sgr_raster_checker
// Watches the byte, column-write and register ports of the sixel glyph
// rasterizer. It predicts every column write from the accepted bytes and the
// written cell size, then compares each accepted write field by field.
// ----------------------------------------------------------------------------
module sgr_raster_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_start_font,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [6:0] rsp_glyph_number,
   input  wire logic [3:0] rsp_column,
   input  wire logic [4:0] rsp_row_base,
   input  wire logic [5:0] rsp_column_bits,
   input  wire logic [5:0] rsp_row_mask,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [5:0] csr_wdata,
   output int              fail_count,
   output int              pending
);

   localparam int CELL_W_MAX = 16;
   localparam int CELL_H_MAX = 32;
   localparam int GLYPH_CAP  = 128;

   logic [4:0]       cfg_width;
   logic [5:0]       cfg_height;
   logic [4:0]       col_cnt;
   logic [5:0]       band_top;
   logic [7:0]       glyph_idx;
   sgr_pkg::rsp_type column_writes_q[$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   task automatic rasterize_byte(input logic [7:0] ch, input logic st);
      int               w;
      int               h;
      int               b;
      int               rows;
      int               mask_i;
      int               bits_i;
      sgr_pkg::rsp_type cw;
      w = (int'(cfg_width) < CELL_W_MAX) ? int'(cfg_width) : CELL_W_MAX;
      h = (int'(cfg_height) < CELL_H_MAX) ? int'(cfg_height) : CELL_H_MAX;
      if (st) begin
         col_cnt   = '0;
         band_top  = '0;
         glyph_idx = '0;
      end
      b = int'(band_top);
      if (ch == sgr_pkg::CH_SLASH) begin
         col_cnt = '0;
         if (b + int'(sgr_pkg::BAND_ROWS) <= int'(sgr_pkg::BAND_CAP)) begin
            band_top = 6'(b + int'(sgr_pkg::BAND_ROWS));
         end
      end else if (ch == sgr_pkg::CH_SEMI) begin
         col_cnt  = '0;
         band_top = '0;
         if (int'(glyph_idx) < GLYPH_CAP) begin
            glyph_idx = glyph_idx + 8'd1;
         end
      end else if (ch >= sgr_pkg::SIXEL_LOW && ch <= sgr_pkg::SIXEL_HIGH
                   && int'(col_cnt) < w) begin
         cw.column = col_cnt[3:0];
         col_cnt   = col_cnt + 5'd1;
         if (b < h && int'(glyph_idx) < GLYPH_CAP) begin
            rows   = h - b;
            mask_i = (rows >= int'(sgr_pkg::BAND_ROWS)) ? 63 : ((1 << rows) - 1);
            bits_i = (int'(ch) - int'(sgr_pkg::SIXEL_LOW)) & mask_i;
            cw.glyph_number = glyph_idx[6:0];
            cw.row_base     = band_top[4:0];
            cw.column_bits  = bits_i[5:0];
            cw.row_mask     = mask_i[5:0];
            column_writes_q.insert(column_writes_q.size(), cw);
         end
      end
   endtask

   always @(posedge clock) begin
      sgr_pkg::rsp_type want;
      if (reset) begin
         cfg_width  = sgr_pkg::CELL_WIDTH_RESET;
         cfg_height = sgr_pkg::CELL_HEIGHT_RESET;
         col_cnt    = '0;
         band_top   = '0;
         glyph_idx  = '0;
         column_writes_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == sgr_pkg::CSR_CELL_WIDTH) begin
               cfg_width = csr_wdata[4:0];
            end else if (csr_index == sgr_pkg::CSR_CELL_HEIGHT) begin
               cfg_height = csr_wdata;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (column_writes_q.size() == 0) begin
               report_mismatch("column write beat with nothing expected");
            end else begin
               want = column_writes_q.pop_front();
               check_field("glyph_number", int'(rsp_glyph_number),
                           int'(want.glyph_number));
               check_field("column", int'(rsp_column), int'(want.column));
               check_field("row_base", int'(rsp_row_base), int'(want.row_base));
               check_field("column_bits", int'(rsp_column_bits),
                           int'(want.column_bits));
               check_field("row_mask", int'(rsp_row_mask), int'(want.row_mask));
            end
         end
         if (req_valid && req_ready) begin
            rasterize_byte(req_char_code, req_start_font);
         end
      end
      pending <= column_writes_q.size();
   end

endmodule

@@ tb/tb_sixel_glyph_rasterizer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sixel_glyph_rasterizer
// Drives sixel font bytes and cell sizes into the rasterizer under several
// sender and receiver idling patterns; a checker beside it scores the writes.
// ----------------------------------------------------------------------------
module tb_sixel_glyph_rasterizer;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_code  = '0;
   logic       req_start_font = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [6:0] rsp_glyph_number;
   logic [3:0] rsp_column;
   logic [4:0] rsp_row_base;
   logic [5:0] rsp_column_bits;
   logic [5:0] rsp_row_mask;
   logic       csr_we         = 1'b0;
   logic       csr_index      = 1'b0;
   logic [5:0] csr_wdata      = '0;

   int fail_count;
   int pending;
   int idle_cycles    = 0;
   int items_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int cur_w          = int'(sgr_pkg::CELL_WIDTH_RESET);
   int cur_h          = int'(sgr_pkg::CELL_HEIGHT_RESET);

   always #1 clock = ~clock;

   sixel_glyph_rasterizer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_start_font   (req_start_font),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_glyph_number (rsp_glyph_number),
      .rsp_column       (rsp_column),
      .rsp_row_base     (rsp_row_base),
      .rsp_column_bits  (rsp_column_bits),
      .rsp_row_mask     (rsp_row_mask),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   sgr_raster_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_start_font   (req_start_font),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_glyph_number (rsp_glyph_number),
      .rsp_column       (rsp_column),
      .rsp_row_base     (rsp_row_base),
      .rsp_column_bits  (rsp_column_bits),
      .rsp_row_mask     (rsp_row_mask),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sixel_glyph_rasterizer test failed");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] ch, input logic st);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_char_code  <= ch;
      req_start_font <= st;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_noise();
      send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
   endtask

   task automatic send_glyph(input bit fresh);
      int   bands;
      int   cols;
      int   w_eff;
      int   h_eff;
      logic st;
      st    = fresh;
      w_eff = (cur_w < 16) ? cur_w : 16;
      h_eff = (cur_h < 32) ? cur_h : 32;
      bands = $urandom_range(1, h_eff / 6 + 2);
      for (int b = 0; b < bands; b++) begin
         if (b != 0) begin
            send_byte(sgr_pkg::CH_SLASH, st);
            st = 1'b0;
         end
         cols = $urandom_range(0, w_eff + 1);
         for (int c = 0; c < cols; c++) begin
            if ($urandom_range(19) == 0) send_noise();
            send_byte(8'(sgr_pkg::SIXEL_LOW + $urandom_range(63)), st);
            st = 1'b0;
         end
      end
      send_byte(sgr_pkg::CH_SEMI, st);
   endtask

   task automatic wait_for_column_writes();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_cell_size(input int w, input int h);
      csr_we    <= 1'b1;
      csr_index <= sgr_pkg::CSR_CELL_WIDTH;
      csr_wdata <= 6'(($urandom_range(1) << 5) | w);
      @(posedge clock);
      csr_index <= sgr_pkg::CSR_CELL_HEIGHT;
      csr_wdata <= 6'(h);
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_w = w;
      cur_h = h;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct  = 71;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 71;
         end
         default: begin
            send_idle_pct  = 38;
            recv_stall_pct = 38;
         end
      endcase
   endtask

   task automatic run_random(input int quota);
      int stop;
      int pick;
      stop = items_sent + quota;
      while (items_sent < stop) begin
         pick = $urandom_range(9);
         if (pick < 7) begin
            send_glyph(pick == 0);
         end else begin
            repeat ($urandom_range(1, 4)) send_noise();
         end
      end
   endtask

   task automatic run_glyph_overflow();
      send_byte(8'(sgr_pkg::SIXEL_LOW + 8'd1), 1'b1);
      repeat (126) send_byte(sgr_pkg::CH_SEMI, 1'b0);
      send_glyph(1'b0);
      send_glyph(1'b0);
      send_glyph(1'b0);
      repeat (3) send_byte(sgr_pkg::CH_SEMI, 1'b0);
      repeat (2) send_byte(sgr_pkg::SIXEL_HIGH, 1'b0);
      send_glyph(1'b1);
   endtask

   task automatic run_band_overflow();
      send_byte(sgr_pkg::CH_SEMI, 1'b1);
      repeat (5) send_byte(sgr_pkg::CH_SLASH, 1'b0);
      repeat (2) send_byte(sgr_pkg::SIXEL_HIGH, 1'b0);
      repeat (8) send_byte(sgr_pkg::CH_SLASH, 1'b0);
      repeat (2) send_byte(sgr_pkg::SIXEL_HIGH, 1'b0);
      send_byte(sgr_pkg::CH_SEMI, 1'b0);
   endtask

   initial begin
      int widths[8];
      int heights[8];
      widths  = '{1, 16, 0, 31, 5, 8, 16, 3};
      heights = '{1, 32, 6, 63, 7, 0, 11, 12};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(sgr_pkg::SIXEL_LOW, 1'b1);
      send_byte(sgr_pkg::SIXEL_HIGH, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'd255, 1'b0);
      send_byte(8'(sgr_pkg::SIXEL_LOW - 8'd1), 1'b0);
      send_byte(8'(sgr_pkg::SIXEL_HIGH + 8'd1), 1'b0);
      send_byte(sgr_pkg::CH_SLASH, 1'b0);
      send_byte(sgr_pkg::SIXEL_HIGH, 1'b0);
      send_byte(sgr_pkg::CH_SLASH, 1'b0);
      send_byte(8'd100, 1'b0);
      send_byte(sgr_pkg::CH_SEMI, 1'b0);
      repeat (9) send_byte(8'(sgr_pkg::SIXEL_LOW + $urandom_range(63)), 1'b0);
      send_byte(sgr_pkg::CH_SEMI, 1'b1);
      send_byte(8'd170, 1'b1);
      send_byte(sgr_pkg::CH_SLASH, 1'b1);
      send_byte(8'd85, 1'b0);

      for (int p = 0; p < 8; p++) begin
         wait_for_column_writes();
         write_cell_size(widths[p], heights[p]);
         set_idling(p % 4);
         run_random(6);
         if (p == 4) run_glyph_overflow();
         if (p == 3) run_band_overflow();
         wait_for_column_writes();
         set_idling((p + 1) % 4);
         run_random(6);
      end

      wait_for_column_writes();
      if (fail_count == 0) begin
         $display("sixel_glyph_rasterizer test passed");
      end else begin
         $display("sixel_glyph_rasterizer test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/sgr_pkg.sv
sv/sgr_decoder.sv
sv/sixel_glyph_rasterizer.sv
tb/sgr_raster_checker.sv
tb/tb_sixel_glyph_rasterizer.sv
